// ===== hw/rtl/bblru_pkg.sv =====
// Shared constants for the byte budget LRU cache.
`default_nettype none
package bblru_pkg;
    localparam logic [2:0] OUT_HIT       = 3'd0;
    localparam logic [2:0] OUT_INSERTED  = 3'd1;
    localparam logic [2:0] OUT_NOT_FOUND = 3'd2;
    localparam logic [2:0] OUT_TOO_LARGE = 3'd3;
    localparam logic [2:0] OUT_DISABLED  = 3'd4;

    localparam logic REG_CACHE_ENABLE   = 1'b0;
    localparam logic REG_CAPACITY_BYTES = 1'b1;
endpackage
`default_nettype wire

// ===== hw/rtl/bblru_store.sv =====
// Slot store: key and cost memories, one read and one write port each.
`default_nettype none
module bblru_store
    import bblru_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int KEY_BITS = 32
)
(
    input  wire logic                      clk,
    input  wire logic [$clog2(SLOTS)-1:0]  rd_addr,
    output logic      [KEY_BITS-1:0]       rd_key,
    output logic      [31:0]               rd_cost,
    input  wire logic                      wr_en,
    input  wire logic [$clog2(SLOTS)-1:0]  wr_addr,
    input  wire logic [KEY_BITS-1:0]       wr_key,
    input  wire logic [31:0]               wr_cost
);
    logic [KEY_BITS-1:0] key_mem [SLOTS];
    logic [31:0]         cost_mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]  <= wr_key;
            cost_mem[wr_addr] <= wr_cost;
        end
        rd_key  <= key_mem[rd_addr];
        rd_cost <= cost_mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/byte_budget_lru_cache_top.sv =====
// Top level of the byte budget LRU cache directory.
//
// Channel   Direction  Handshake          Word
// cfg       in         cfg_we             cfg_index, cfg_data
// request   in         in_valid/in_ready  file_key, file_exists, file_size
// result    out        out_valid/out_ready outcome, evicted_count, bytes_cached
//
// A request is handled by a sequencer that reads the slot memory one entry a
// cycle. The lookup walks every slot; each eviction takes one further walk of
// the slot ages, one memory read of the victim's cost and the subtraction,
// followed by a fresh decision, or by the insertion straight away when only a
// free slot was lacking; an insertion writes the new entry. Ages and valid
// bits sit in flip-flops, reset to zero; keys and costs are undefined until
// written and need no clearing pass.
// The result is held in an output register: a stalled consumer only holds the
// sequencer once a finished word waits there.
`default_nettype none
module byte_budget_lru_cache_top
    import bblru_pkg::*;
#(
    parameter int SLOTS    = 16,
    parameter int KEY_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] file_key,
    input  wire logic        file_exists,
    input  wire logic [31:0] file_size,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       outcome,
    output logic [4:0]       evicted_count,
    output logic [31:0]      bytes_cached
);
    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOK   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_FIND   = 3'd3;
    localparam logic [2:0] ST_EVRD   = 3'd4;
    localparam logic [2:0] ST_EVSUB  = 3'd5;
    localparam logic [2:0] ST_INSERT = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    // Configuration registers.
    logic        enable_reg;
    logic [31:0] capacity_reg;

    // Per-slot state in flip-flops.
    logic [SLOTS-1:0] valid_reg;
    logic [AW-1:0]    age_reg [SLOTS];

    logic [2:0]          state_reg;
    logic [CW-1:0]       idx_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic                exists_reg;
    logic [32:0]         cost_reg;
    logic [31:0]         bytes_reg;
    logic                hit_found_reg;
    logic [AW-1:0]       hit_slot_reg;
    logic [AW-1:0]       victim_reg;
    logic                victim_ok_reg;
    logic [AW-1:0]       pend_addr_reg;
    logic                pend_reg;
    logic [4:0]          evicted_reg;
    logic                full_evict_reg;

    logic        out_valid_reg;
    logic [2:0]  outcome_reg;
    logic [2:0]  outcome_out_reg;
    logic [4:0]  evicted_out_reg;
    logic [31:0] bytes_out_reg;

    logic [KEY_BITS-1:0] rd_key;
    logic [31:0]         rd_cost;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       free_slot;
    logic                has_free;

    bblru_store #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_store (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_cost (rd_cost),
        .wr_en   (wr_en),
        .wr_addr (free_slot),
        .wr_key  (key_reg),
        .wr_cost (cost_reg[31:0])
    );

    always_comb
    begin
        rd_addr = (state_reg == ST_LOOK) ? idx_reg[AW-1:0] : victim_reg;
        wr_en   = (state_reg == ST_INSERT);
    end

    // Lowest invalid slot, a priority encode over the valid bits.
    always_comb
    begin
        has_free  = 1'b0;
        free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                has_free  = 1'b1;
                free_slot = AW'(i);
            end
        end
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign outcome       = outcome_out_reg;
    assign evicted_count = evicted_out_reg;
    assign bytes_cached  = bytes_out_reg;

    logic [32:0] need;
    assign need = {1'b0, bytes_reg} + cost_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            capacity_reg  <= '0;
            valid_reg     <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                age_reg[i] <= '0;
            end
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            bytes_reg     <= '0;
            out_valid_reg <= 1'b0;
            hit_found_reg <= 1'b0;
            pend_reg      <= 1'b0;
            victim_ok_reg <= 1'b0;
            evicted_reg   <= '0;
            full_evict_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_CACHE_ENABLE)
                begin
                    enable_reg <= cfg_data[0];
                end
                else
                begin
                    capacity_reg <= cfg_data;
                end
            end
            // The finishing state refills the output register itself.
            if (out_valid_reg && out_ready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        key_reg       <= KEY_BITS'(file_key);
                        exists_reg    <= file_exists;
                        cost_reg      <= {1'b0, file_size} + 33'd1;
                        idx_reg       <= '0;
                        hit_found_reg <= 1'b0;
                        pend_reg      <= 1'b0;
                        evicted_reg   <= '0;
                        full_evict_reg <= 1'b0;
                        if (!enable_reg)
                        begin
                            outcome_reg <= OUT_DISABLED;
                            state_reg   <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_LOOK;
                        end
                    end
                end
                ST_LOOK:
                begin
                    // Compare the entry read in the previous cycle.
                    if (pend_reg && valid_reg[pend_addr_reg] && rd_key == key_reg
                        && !hit_found_reg)
                    begin
                        hit_found_reg <= 1'b1;
                        hit_slot_reg  <= pend_addr_reg;
                    end
                    pend_reg      <= (idx_reg < CW'(SLOTS));
                    pend_addr_reg <= idx_reg[AW-1:0];
                    if (idx_reg == CW'(SLOTS))
                    begin
                        state_reg <= ST_DECIDE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                ST_DECIDE:
                begin
                    if (hit_found_reg)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (valid_reg[i] && age_reg[i] < age_reg[hit_slot_reg])
                            begin
                                age_reg[i] <= age_reg[i] + AW'(1);
                            end
                        end
                        age_reg[hit_slot_reg] <= '0;
                        outcome_reg <= OUT_HIT;
                        state_reg   <= ST_DONE;
                    end
                    else if (!exists_reg)
                    begin
                        outcome_reg <= OUT_NOT_FOUND;
                        state_reg   <= ST_DONE;
                    end
                    else if (cost_reg > {1'b0, capacity_reg})
                    begin
                        outcome_reg <= OUT_TOO_LARGE;
                        state_reg   <= ST_DONE;
                    end
                    else if (need > {1'b0, capacity_reg} || !has_free)
                    begin
                        full_evict_reg <= !(need > {1'b0, capacity_reg});
                        idx_reg        <= '0;
                        victim_ok_reg  <= 1'b0;
                        state_reg      <= ST_FIND;
                    end
                    else
                    begin
                        state_reg <= ST_INSERT;
                    end
                end
                ST_FIND:
                begin
                    // Oldest valid slot, one slot a cycle.
                    if (idx_reg == CW'(SLOTS))
                    begin
                        state_reg <= victim_ok_reg ? ST_EVRD : ST_DONE;
                        if (!victim_ok_reg)
                        begin
                            outcome_reg <= OUT_TOO_LARGE;
                        end
                    end
                    else
                    begin
                        if (valid_reg[idx_reg[AW-1:0]] && (!victim_ok_reg
                            || age_reg[idx_reg[AW-1:0]] > age_reg[victim_reg]))
                        begin
                            victim_reg    <= idx_reg[AW-1:0];
                            victim_ok_reg <= 1'b1;
                        end
                        idx_reg <= idx_reg + CW'(1);
                    end
                end
                ST_EVRD:
                begin
                    // Cost read is under way.
                    state_reg <= ST_EVSUB;
                end
                ST_EVSUB:
                begin
                    bytes_reg              <= bytes_reg - rd_cost;
                    valid_reg[victim_reg]  <= 1'b0;
                    evicted_reg            <= evicted_reg + 5'd1;
                    if (full_evict_reg)
                    begin
                        state_reg <= ST_INSERT;
                    end
                    else
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_INSERT:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (valid_reg[i])
                        begin
                            age_reg[i] <= age_reg[i] + AW'(1);
                        end
                    end
                    age_reg[free_slot]   <= '0;
                    valid_reg[free_slot] <= 1'b1;
                    bytes_reg            <= bytes_reg + cost_reg[31:0];
                    outcome_reg          <= OUT_INSERTED;
                    state_reg            <= ST_DONE;
                end
                default:
                begin
                    // Hand the word over once the output register is free.
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        outcome_out_reg <= outcome_reg;
                        evicted_out_reg <= evicted_reg;
                        bytes_out_reg   <= bytes_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // A request is only taken while no work is in progress.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");

    // An insertion always leaves its slot valid.
    a_insert_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INSERT) |=> valid_reg[$past(free_slot)])
        else $error("inserted slot not valid");

    // A waiting result is never overwritten.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(bytes_cached)
            && $stable(outcome) && $stable(evicted_count))
        else $error("result lost");
endmodule
`default_nettype wire
